/* hdl/tcw_pkg.sv */
// shared constants, codes and types for the text console writer
package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = ROWS * COLUMNS;

   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int CELL_W = 16;
   localparam int ATTR_W = 8;
   localparam int CHAR_W = 8;
   localparam int FUNC_W = 2;
   localparam int CSR_W  = 1;

   localparam int ADDR_W = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);

   localparam logic [FUNC_W-1:0] FN_PUT   = 2'd0;
   localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd1;
   localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

   localparam logic [CSR_W-1:0] CSR_TEXT_ATTR    = 1'd0;
   localparam logic [CSR_W-1:0] CSR_DEFAULT_ATTR = 1'd1;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;
   localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd15;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_FILL
   } state_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [CELL_W-1:0] wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic             load;
      logic             use_rdata;
      logic [ROW_W-1:0] cursor_row;
      logic [COL_W-1:0] cursor_col;
   } rsp_load_type;

endpackage

/* hdl/tcw_ram.sv */
// generic single write port, single read port ram with registered read
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/tcw_ctrl.sv */
// sequencer: cursor, request decode and the address counter that walks the store
module tcw_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [tcw_pkg::FUNC_W-1:0]   req_func,
   input  logic [tcw_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tcw_pkg::ROW_W-1:0]    req_read_row,
   input  logic [tcw_pkg::COL_W-1:0]    req_read_col,
   input  logic                         rsp_free,
   input  logic [tcw_pkg::ATTR_W-1:0]   text_attr,
   input  logic [tcw_pkg::ATTR_W-1:0]   default_attr,
   input  logic [tcw_pkg::CELL_W-1:0]   mem_rdata,
   output tcw_pkg::mem_req_type         mem_req,
   output tcw_pkg::rsp_load_type        rsp_load
);

   tcw_pkg::state_type              state_ff, state_in;
   logic [tcw_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic                            pend_ff, pend_in;
   logic [tcw_pkg::ADDR_W-1:0]      dst_ff, dst_in;
   logic [tcw_pkg::ROW_W-1:0]       row_ff, row_in;
   logic [tcw_pkg::COL_W-1:0]       col_ff, col_in;

   logic                            accept;
   logic                            read_in_range;
   logic [tcw_pkg::CNT_W-1:0]       put_addr;
   logic [tcw_pkg::CNT_W-1:0]       rd_addr;
   logic [tcw_pkg::CELL_W-1:0]      blank_cell;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcw_pkg::ST_INIT;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
      dst_ff <= dst_in;
   end

   assign put_addr = tcw_pkg::CNT_W'(row_ff) * tcw_pkg::CNT_W'(tcw_pkg::COLUMNS)
                   + tcw_pkg::CNT_W'(col_ff);
   assign rd_addr  = tcw_pkg::CNT_W'(req_read_row) * tcw_pkg::CNT_W'(tcw_pkg::COLUMNS)
                   + tcw_pkg::CNT_W'(req_read_col);
   assign read_in_range = (req_read_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS))
                       && (req_read_col < tcw_pkg::COL_W'(tcw_pkg::COLUMNS));
   assign blank_cell = {default_attr, tcw_pkg::BLANK_CODE};

   assign req_stall = !((state_ff == tcw_pkg::ST_IDLE) && rsp_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pend_in  = pend_ff;
      dst_in   = dst_ff;
      row_in   = row_ff;
      col_in   = col_ff;

      mem_req.we    = 1'b0;
      mem_req.waddr = cnt_ff[tcw_pkg::ADDR_W-1:0];
      mem_req.wdata = blank_cell;
      mem_req.raddr = rd_addr[tcw_pkg::ADDR_W-1:0];

      rsp_load.load      = 1'b0;
      rsp_load.use_rdata = 1'b0;

      case (state_ff)
         tcw_pkg::ST_INIT: begin
            // zero the whole store after reset
            mem_req.we    = 1'b1;
            mem_req.wdata = '0;
            if (cnt_ff == tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1)) begin
               cnt_in   = '0;
               state_in = tcw_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         tcw_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  tcw_pkg::FN_PUT: begin
                     if (req_char_code == tcw_pkg::NEWLINE_CODE) begin
                        col_in = '0;
                        if (row_ff == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) begin
                           cnt_in   = tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);
                           pend_in  = 1'b0;
                           state_in = tcw_pkg::ST_SCROLL;
                        end else begin
                           row_in        = row_ff + 1'b1;
                           rsp_load.load = 1'b1;
                        end
                     end else begin
                        if (col_ff < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)) begin
                           mem_req.we    = 1'b1;
                           mem_req.waddr = put_addr[tcw_pkg::ADDR_W-1:0];
                           mem_req.wdata = {text_attr, req_char_code};
                           col_in        = col_ff + 1'b1;
                        end
                        rsp_load.load = 1'b1;
                     end
                  end
                  tcw_pkg::FN_CLEAR: begin
                     cnt_in   = '0;
                     state_in = tcw_pkg::ST_FILL;
                  end
                  tcw_pkg::FN_READ: begin
                     if (read_in_range) begin
                        state_in = tcw_pkg::ST_READ;
                     end else begin
                        rsp_load.load = 1'b1;
                     end
                  end
                  default: begin
                     rsp_load.load = 1'b1;
                  end
               endcase
            end
         end
         tcw_pkg::ST_READ: begin
            rsp_load.load      = 1'b1;
            rsp_load.use_rdata = 1'b1;
            state_in           = tcw_pkg::ST_IDLE;
         end
         tcw_pkg::ST_SCROLL: begin
            // read one row ahead, write the word in the next cycle one row up
            mem_req.raddr = cnt_ff[tcw_pkg::ADDR_W-1:0];
            if (cnt_ff < tcw_pkg::CNT_W'(tcw_pkg::CELLS)) begin
               pend_in = 1'b1;
               dst_in  = tcw_pkg::ADDR_W'(cnt_ff - tcw_pkg::CNT_W'(tcw_pkg::COLUMNS));
               cnt_in  = cnt_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = dst_ff;
               mem_req.wdata = mem_rdata;
            end
            if ((cnt_ff >= tcw_pkg::CNT_W'(tcw_pkg::CELLS)) && !pend_ff) begin
               cnt_in   = tcw_pkg::CNT_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
               state_in = tcw_pkg::ST_FILL;
            end
         end
         tcw_pkg::ST_FILL: begin
            mem_req.we = 1'b1;
            if (cnt_ff >= tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1)) begin
               cnt_in        = '0;
               rsp_load.load = 1'b1;
               state_in      = tcw_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase

      rsp_load.cursor_row = row_in;
      rsp_load.cursor_col = col_in;
   end

endmodule

/* hdl/text_console_writer_top.sv */
// top level of the text console writer: attribute registers, result register, store
//
// Text console with an 80 by 25 store of 16-bit cells (attribute high byte,
// character low byte) and a cursor. For a printable put, a newline that does
// not scroll, a read out of range and an unused code the result word is
// loaded at the edge that takes the request. The result of an in-range read
// is loaded in ST_READ, because of the registered read of the store. A clear
// goes to ST_FILL, which writes a blank cell to every cell of the store. A
// newline on the bottom row moves the rows up in ST_SCROLL and then blanks
// the bottom row in ST_FILL. Both are driven by the address counter that walks
// the store one cell a cycle through its single write port. After reset the
// block zeroes the whole store and holds req_stall high meanwhile; attribute
// writes are taken at any time.
// A new request is taken while the previous result word is being taken.
module text_console_writer_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [tcw_pkg::FUNC_W-1:0]   req_func,
   input  logic [tcw_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tcw_pkg::ROW_W-1:0]    req_read_row,
   input  logic [tcw_pkg::COL_W-1:0]    req_read_col,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [tcw_pkg::ROW_W-1:0]    rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0]    rsp_cursor_col,
   output logic [tcw_pkg::CELL_W-1:0]   rsp_cell_value,
   input  logic                         csr_wr_en,
   input  logic [tcw_pkg::CSR_W-1:0]    csr_index,
   input  logic [tcw_pkg::ATTR_W-1:0]   csr_wdata
);

   logic [tcw_pkg::ATTR_W-1:0]  text_attr_ff, text_attr_in;
   logic [tcw_pkg::ATTR_W-1:0]  default_attr_ff, default_attr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::ROW_W-1:0]   rsp_row_ff, rsp_row_in;
   logic [tcw_pkg::COL_W-1:0]   rsp_col_ff, rsp_col_in;
   logic [tcw_pkg::CELL_W-1:0]  rsp_cell_ff, rsp_cell_in;

   logic                        rsp_free;
   logic [tcw_pkg::CELL_W-1:0]  mem_rdata;
   tcw_pkg::mem_req_type        mem_req;
   tcw_pkg::rsp_load_type       rsp_load;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   tcw_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_char_code (req_char_code),
      .req_read_row  (req_read_row),
      .req_read_col  (req_read_col),
      .rsp_free      (rsp_free),
      .text_attr     (text_attr_ff),
      .default_attr  (default_attr_ff),
      .mem_rdata     (mem_rdata),
      .mem_req       (mem_req),
      .rsp_load      (rsp_load)
   );

   tcw_ram #(
      .WIDTH (tcw_pkg::CELL_W),
      .DEPTH (tcw_pkg::CELLS)
   ) u_screen_ram (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .raddr (mem_req.raddr),
      .rdata (mem_rdata)
   );

   always_comb begin
      text_attr_in    = text_attr_ff;
      default_attr_in = default_attr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            tcw_pkg::CSR_TEXT_ATTR:    text_attr_in    = csr_wdata;
            tcw_pkg::CSR_DEFAULT_ATTR: default_attr_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_cell_in  = rsp_cell_ff;
      if (rsp_load.load) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = rsp_load.cursor_row;
         rsp_col_in   = rsp_load.cursor_col;
         rsp_cell_in  = rsp_load.use_rdata ? mem_rdata : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_attr_ff    <= tcw_pkg::ATTR_RESET;
         default_attr_ff <= tcw_pkg::ATTR_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         text_attr_ff    <= text_attr_in;
         default_attr_ff <= default_attr_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cell_value = rsp_cell_ff;

   // a held result word must block new requests
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("request taken while result word is held");

   // cursor row stays on the screen, cursor column at most one past the last column
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_row_ff < tcw_pkg::ROW_W'(tcw_pkg::ROWS))
                    && (rsp_col_ff <= tcw_pkg::COL_W'(tcw_pkg::COLUMNS)))
      else $error("cursor out of range");

   // a clear walks the store, so the next cycle cannot take a request
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_func == tcw_pkg::FN_CLEAR) |=> req_stall)
      else $error("request taken during clear");

   // no result word may be loaded while one is still held
   assert property (@(posedge clock) disable iff (reset)
      rsp_load.load |-> rsp_free)
      else $error("result word overwritten");

endmodule

/* dv/text_console_writer_top_tb.sv */
// self-checking testbench for the text console writer with a cursor and screen predictor
module text_console_writer_top_tb;

   localparam logic [tcw_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [tcw_pkg::ROW_W-1:0] LAST_ROW = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
   localparam logic [tcw_pkg::COL_W-1:0] LAST_COL = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);

   typedef struct packed {
      logic [tcw_pkg::ROW_W-1:0]  row;
      logic [tcw_pkg::COL_W-1:0]  col;
      logic [tcw_pkg::CELL_W-1:0] cell_val;
   } cursor_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [tcw_pkg::FUNC_W-1:0]  req_func = '0;
   logic [tcw_pkg::CHAR_W-1:0]  req_char_code = '0;
   logic [tcw_pkg::ROW_W-1:0]   req_read_row = '0;
   logic [tcw_pkg::COL_W-1:0]   req_read_col = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [tcw_pkg::ROW_W-1:0]   rsp_cursor_row;
   logic [tcw_pkg::COL_W-1:0]   rsp_cursor_col;
   logic [tcw_pkg::CELL_W-1:0]  rsp_cell_value;
   logic                        csr_wr_en = 1'b0;
   logic [tcw_pkg::CSR_W-1:0]   csr_index = '0;
   logic [tcw_pkg::ATTR_W-1:0]  csr_wdata = '0;

   // predicted screen, cursor and attribute registers
   logic [tcw_pkg::CELL_W-1:0]  shadow_cells [tcw_pkg::CELLS];
   logic [tcw_pkg::ROW_W-1:0]   shadow_row = '0;
   logic [tcw_pkg::COL_W-1:0]   shadow_col = '0;
   logic [tcw_pkg::ATTR_W-1:0]  text_attr_model = tcw_pkg::ATTR_RESET;
   logic [tcw_pkg::ATTR_W-1:0]  blank_attr_model = tcw_pkg::ATTR_RESET;

   cursor_report_type pending_reports[$];
   int  words_sent = 0;
   int  errors = 0;
   int  idle_cycles = 0;
   int  sink_hold = 0;
   bit  calm = 1'b0;

   text_console_writer_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_char_code  (req_char_code),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cell_value (rsp_cell_value),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [tcw_pkg::ROW_W-1:0] rand_row(input int hi);
      return tcw_pkg::ROW_W'($urandom_range(0, hi));
   endfunction

   function automatic logic [tcw_pkg::COL_W-1:0] rand_col(input int hi);
      return tcw_pkg::COL_W'($urandom_range(0, hi));
   endfunction

   function automatic logic [tcw_pkg::CHAR_W-1:0] rand_char();
      return tcw_pkg::CHAR_W'($urandom_range(0, 255));
   endfunction

   function automatic cursor_report_type apply_request(
         input logic [tcw_pkg::FUNC_W-1:0] fn,
         input logic [tcw_pkg::CHAR_W-1:0] ch,
         input logic [tcw_pkg::ROW_W-1:0]  rr,
         input logic [tcw_pkg::COL_W-1:0]  rc);
      cursor_report_type rep;
      rep.cell_val = '0;
      case (fn)
         tcw_pkg::FN_PUT: begin
            if (ch == tcw_pkg::NEWLINE_CODE) begin
               if (int'(shadow_row) + 1 >= tcw_pkg::ROWS) begin
                  for (int i = 0; i < tcw_pkg::CELLS - tcw_pkg::COLUMNS; i++)
                     shadow_cells[i] = shadow_cells[i + tcw_pkg::COLUMNS];
                  for (int i = tcw_pkg::CELLS - tcw_pkg::COLUMNS; i < tcw_pkg::CELLS; i++)
                     shadow_cells[i] = {blank_attr_model, tcw_pkg::BLANK_CODE};
                  shadow_row = LAST_ROW;
               end else begin
                  shadow_row = shadow_row + 1'b1;
               end
               shadow_col = '0;
            end else if (shadow_col < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)) begin
               shadow_cells[int'(shadow_row) * tcw_pkg::COLUMNS + int'(shadow_col)] =
                  {text_attr_model, ch};
               shadow_col = shadow_col + 1'b1;
            end
         end
         tcw_pkg::FN_CLEAR: begin
            for (int i = 0; i < tcw_pkg::CELLS; i++)
               shadow_cells[i] = {blank_attr_model, tcw_pkg::BLANK_CODE};
         end
         tcw_pkg::FN_READ: begin
            if (int'(rr) < tcw_pkg::ROWS && int'(rc) < tcw_pkg::COLUMNS)
               rep.cell_val = shadow_cells[int'(rr) * tcw_pkg::COLUMNS + int'(rc)];
         end
         default: ;
      endcase
      rep.row = shadow_row;
      rep.col = shadow_col;
      return rep;
   endfunction

   // valid stays high across back-to-back words, dropped only for a gap
   task automatic send_word(input logic [tcw_pkg::FUNC_W-1:0] fn,
                            input logic [tcw_pkg::CHAR_W-1:0] ch,
                            input logic [tcw_pkg::ROW_W-1:0]  rr,
                            input logic [tcw_pkg::COL_W-1:0]  rc);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_func      <= fn;
      req_char_code <= ch;
      req_read_row  <= rr;
      req_read_col  <= rc;
      do @(posedge clock); while (req_stall);
      pending_reports.push_back(apply_request(fn, ch, rr, rc));
      words_sent++;
   endtask

   task automatic send_put(input logic [tcw_pkg::CHAR_W-1:0] ch);
      send_word(tcw_pkg::FN_PUT, ch, rand_row(31), rand_col(127));
   endtask

   task automatic send_read(input logic [tcw_pkg::ROW_W-1:0] rr,
                            input logic [tcw_pkg::COL_W-1:0] rc);
      send_word(tcw_pkg::FN_READ, rand_char(), rr, rc);
   endtask

   function automatic logic [tcw_pkg::CHAR_W-1:0] random_glyph();
      logic [tcw_pkg::CHAR_W-1:0] ch;
      do ch = rand_char(); while (ch == tcw_pkg::NEWLINE_CODE);
      return ch;
   endfunction

   task automatic write_attr(input logic [tcw_pkg::CSR_W-1:0] idx,
                             input logic [tcw_pkg::ATTR_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == tcw_pkg::CSR_TEXT_ATTR) text_attr_model = val;
      else blank_attr_model = val;
   endtask

   // all results back and no clear or scroll still walking the store
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      do @(posedge clock); while (req_stall);
   endtask

   task automatic test_reset_contents();
      send_read('0, '0);
      send_read(LAST_ROW, LAST_COL);
      send_read(5'd12, 7'd40);
      send_word(FN_UNUSED, '0, '0, '0);
   endtask

   task automatic test_operation_extremes();
      send_put(8'h00);
      send_put(8'hFF);
      send_put(8'd65);
      send_read('0, '0);
      send_read('0, 7'd1);
      send_read('0, 7'd2);
      send_word(FN_UNUSED, 8'hFF, 5'd31, 7'd127);
      // clear carrying a newline code must leave the cursor alone
      send_word(tcw_pkg::FN_CLEAR, tcw_pkg::NEWLINE_CODE, 5'd31, 7'd127);
      send_read('0, '0);
      send_read(LAST_ROW, LAST_COL);
      send_put(tcw_pkg::NEWLINE_CODE);
      send_put(8'd90);
      send_read(5'd1, '0);
      send_read(5'd31, 7'd127);
      send_read(tcw_pkg::ROW_W'(tcw_pkg::ROWS), '0);
      send_read('0, tcw_pkg::COL_W'(tcw_pkg::COLUMNS));
   endtask

   task automatic test_right_edge();
      logic [tcw_pkg::ROW_W-1:0] line_row;
      send_put(tcw_pkg::NEWLINE_CODE);
      line_row = shadow_row;
      repeat (tcw_pkg::COLUMNS + 5) send_put(random_glyph());
      send_read(line_row, '0);
      send_read(line_row, LAST_COL);
      send_read(line_row, rand_col(tcw_pkg::COLUMNS - 1));
      send_put(tcw_pkg::NEWLINE_CODE);
   endtask

   task automatic test_bottom_scroll();
      while (shadow_row < LAST_ROW) send_put(tcw_pkg::NEWLINE_CODE);
      repeat (5) send_put(random_glyph());
      for (int c = 0; c < 5; c++) send_read(LAST_ROW, tcw_pkg::COL_W'(c));
      repeat (3) begin
         send_put(tcw_pkg::NEWLINE_CODE);
         send_read(LAST_ROW - 1'b1, '0);
         send_read(LAST_ROW, '0);
         send_put(random_glyph());
      end
      send_read('0, '0);
   endtask

   task automatic test_random_traffic(input int count);
      int stop_at;
      int roll;
      int len;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0) calm = !calm;
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            // mostly short lines, now and then one that runs off the right edge
            len = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 20)
                                              : $urandom_range(60, 100);
            repeat (len) send_put(random_glyph());
            if ($urandom_range(0, 4) != 0) send_put(tcw_pkg::NEWLINE_CODE);
         end else if (roll < 92) begin
            repeat ($urandom_range(1, 8)) begin
               roll = $urandom_range(0, 9);
               if (roll == 0)
                  send_read(rand_row(31), rand_col(127));
               else if (roll < 5 && shadow_row > 0)
                  send_read(shadow_row - tcw_pkg::ROW_W'($urandom_range(0, 1)),
                            rand_col(tcw_pkg::COLUMNS - 1));
               else
                  send_read(rand_row(tcw_pkg::ROWS - 1), rand_col(tcw_pkg::COLUMNS - 1));
            end
         end else if (roll < 95) begin
            send_word(tcw_pkg::FN_CLEAR, rand_char(), rand_row(31), rand_col(127));
         end else begin
            send_word(FN_UNUSED, rand_char(), rand_row(31), rand_col(127));
         end
      end
      calm = 1'b0;
   endtask

   always @(negedge clock) begin
      if (sink_hold > 0) begin
         sink_hold <= sink_hold - 1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 35);
         sink_hold <= pick_gap();
      end
   end

   always @(posedge clock) begin : check_results
      cursor_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $error("unexpected result word: row %0d col %0d cell %h",
                   rsp_cursor_row, rsp_cursor_col, rsp_cell_value);
            errors++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_cursor_row !== want.row) begin
               $error("cursor_row mismatch: expected %0d, got %0d", want.row, rsp_cursor_row);
               errors++;
            end
            if (rsp_cursor_col !== want.col) begin
               $error("cursor_col mismatch: expected %0d, got %0d", want.col, rsp_cursor_col);
               errors++;
            end
            if (rsp_cell_value !== want.cell_val) begin
               $error("cell_value mismatch: expected %h, got %h",
                      want.cell_val, rsp_cell_value);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      foreach (shadow_cells[i]) shadow_cells[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_contents();
      wait_idle();
      write_attr(tcw_pkg::CSR_TEXT_ATTR, 8'h00);
      write_attr(tcw_pkg::CSR_DEFAULT_ATTR, 8'hFF);
      test_operation_extremes();
      wait_idle();
      write_attr(tcw_pkg::CSR_TEXT_ATTR, 8'hFF);
      write_attr(tcw_pkg::CSR_DEFAULT_ATTR, 8'h00);
      test_right_edge();
      test_bottom_scroll();
      repeat (4) begin
         wait_idle();
         write_attr(tcw_pkg::CSR_TEXT_ATTR, tcw_pkg::ATTR_W'($urandom_range(0, 255)));
         write_attr(tcw_pkg::CSR_DEFAULT_ATTR, tcw_pkg::ATTR_W'($urandom_range(0, 255)));
         test_random_traffic(460);
      end
      wait_idle();
      repeat (50) @(posedge clock);

      if (errors == 0 && pending_reports.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* text_console_writer_top.f */
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_ctrl.sv
hdl/text_console_writer_top.sv
dv/text_console_writer_top_tb.sv
